FILE: rtl/mdsl_pkg.sv
// Package for the motor duty slew limiter.
// Holds field widths, full-scale constants and configuration register indexes.
// No dependencies.
package mdsl_pkg;

    localparam int DUTY_W     = 16;
    localparam int MAG_W      = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_BITS  = 14;

    localparam logic [MAG_W-1:0] FULL_SCALE = 15'd16384;
    localparam logic [MAG_W-1:0] HALF_LSB   = 15'd8192;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_POL   = 3'd4;

    localparam logic [MAG_W-1:0] DEADBAND_RST  = 15'd164;
    localparam logic [MAG_W-1:0] SLEW_STEP_RST = 15'd1638;
    localparam logic [MAG_W-1:0] MIN_DUTY_RST  = 15'd0;
    localparam logic [MAG_W-1:0] MAX_DUTY_RST  = 15'd16384;

    typedef logic signed [DUTY_W-1:0] duty_t;
    typedef logic [MAG_W-1:0]         mag_t;

endpackage

FILE: rtl/motor_duty_slew_limiter_unit.sv
// Motor duty slew limiter: deadband, clamp, slew limit and duty mapping.
// Three-register pipeline with valid/ready flow control on both channels.
// Depends on mdsl_pkg.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  request | in_valid, in_ready, requested_duty              | in
//  result  | out_valid, out_ready, duty_magnitude,           | out
//          | direction_pin, applied_duty                     |
//  config  | cfg_write, cfg_index, cfg_data                  | in
//
// One item per cycle while the result channel is not stalled; an accepted item passes through the input, middle and
// output registers before its result is presented. The stored limited value is updated as an item leaves the input
// register, so consecutive items see each other's result without waiting.
// Reset clears the stored value, all valid flags and restores register defaults.
// Each stage holds while the stage after it is full and not moving.
module motor_duty_slew_limiter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mdsl_pkg::DUTY_W-1:0]  requested_duty,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mdsl_pkg::MAG_W-1:0]          duty_magnitude,
    output logic                                direction_pin,
    output logic signed [mdsl_pkg::DUTY_W-1:0]  applied_duty,
    input  logic                                cfg_write,
    input  logic [mdsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mdsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mdsl_pkg::*;

    mag_t  deadband_reg;
    mag_t  slew_step_reg;
    mag_t  min_duty_reg;
    mag_t  max_duty_reg;
    logic  fwd_pol_reg;

    duty_t last_reg;
    duty_t last_next;

    logic  in_valid_reg;
    duty_t in_duty_reg;
    logic  mid_valid_reg;
    duty_t mid_lim_reg;
    logic  out_valid_reg;
    mag_t  out_mag_reg;
    logic  out_pin_reg;
    duty_t out_applied_reg;

    logic  out_free;
    logic  mid_free;
    logic  in_free;
    logic  mid_load;
    logic  out_load;

    logic signed [DUTY_W:0] req_ext;
    logic [DUTY_W:0]        req_abs;
    logic                   in_dead;
    duty_t                  clamped;
    logic signed [DUTY_W:0] diff;
    logic [DUTY_W:0]        diff_abs;
    logic signed [DUTY_W:0] step_ext;
    logic signed [DUTY_W:0] cur_ext;
    logic signed [DUTY_W:0] slewed;

    mag_t                   lim_abs;
    mag_t                   min_sat;
    mag_t                   span;
    logic [2*MAG_W-1:0]     prod;
    logic [2*MAG_W:0]       rounded;
    logic [DUTY_W:0]        mapped;
    mag_t                   mag_next;
    logic                   pin_next;
    duty_t                  applied_next;

    assign out_free = !out_valid_reg || out_ready;
    assign mid_free = !mid_valid_reg || out_free;
    assign in_free  = !in_valid_reg || mid_free;
    assign mid_load = in_valid_reg && mid_free;
    assign out_load = mid_valid_reg && out_free;

    assign in_ready  = in_free;
    assign out_valid = out_valid_reg;
    assign duty_magnitude = out_mag_reg;
    assign direction_pin  = out_pin_reg;
    assign applied_duty   = out_applied_reg;

    // deadband, clamp and slew limit
    always_comb
    begin
        req_ext  = {in_duty_reg[DUTY_W-1], in_duty_reg};
        req_abs  = req_ext[DUTY_W] ? (DUTY_W+1)'(0) - req_ext : req_ext;
        in_dead  = req_abs < {2'b00, deadband_reg};
        if (in_duty_reg > $signed({1'b0, FULL_SCALE}))
            clamped = $signed({1'b0, FULL_SCALE});
        else if (in_duty_reg < -$signed({1'b0, FULL_SCALE}))
            clamped = -$signed({1'b0, FULL_SCALE});
        else
            clamped = in_duty_reg;
        cur_ext  = {last_reg[DUTY_W-1], last_reg};
        step_ext = $signed({2'b00, slew_step_reg});
        diff     = $signed({clamped[DUTY_W-1], clamped}) - cur_ext;
        diff_abs = diff[DUTY_W] ? (DUTY_W+1)'(0) - diff : diff;
        if (diff_abs > {2'b00, slew_step_reg})
            slewed = diff[DUTY_W] ? cur_ext - step_ext : cur_ext + step_ext;
        else
            slewed = {clamped[DUTY_W-1], clamped};
        last_next = in_dead ? '0 : slewed[DUTY_W-1:0];
    end

    // map nonzero magnitude onto min_duty..full scale (zero stays zero) and cap at max_duty
    always_comb
    begin
        lim_abs  = mid_lim_reg[DUTY_W-1] ? MAG_W'(-mid_lim_reg) : mid_lim_reg[MAG_W-1:0];
        min_sat  = (min_duty_reg > FULL_SCALE) ? FULL_SCALE : min_duty_reg;
        span     = FULL_SCALE - min_sat;
        prod     = (2*MAG_W)'(lim_abs) * (2*MAG_W)'(span);
        rounded  = {1'b0, prod} + {{(MAG_W+1){1'b0}}, HALF_LSB};
        mapped   = rounded[2*MAG_W:FRAC_BITS] + {2'b00, min_sat};
        if (mid_lim_reg == '0)
            mag_next = '0;
        else if (mapped > {2'b00, max_duty_reg})
            mag_next = max_duty_reg;
        else
            mag_next = mapped[MAG_W-1:0];
        pin_next     = mid_lim_reg[DUTY_W-1] ? !fwd_pol_reg : fwd_pol_reg;
        applied_next = mid_lim_reg[DUTY_W-1] ? -$signed({1'b0, mag_next})
                                             :  $signed({1'b0, mag_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            slew_step_reg <= SLEW_STEP_RST;
            min_duty_reg  <= MIN_DUTY_RST;
            max_duty_reg  <= MAX_DUTY_RST;
            fwd_pol_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DEADBAND:  deadband_reg  <= cfg_data;
                REG_SLEW_STEP: slew_step_reg <= cfg_data;
                REG_MIN_DUTY:  min_duty_reg  <= cfg_data;
                REG_MAX_DUTY:  max_duty_reg  <= cfg_data;
                REG_FWD_POL:   fwd_pol_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= in_valid;
            if (mid_free)
                mid_valid_reg <= in_valid_reg;
            if (out_free)
                out_valid_reg <= mid_valid_reg;
            if (mid_load)
                last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
            in_duty_reg <= requested_duty;
        if (mid_load)
            mid_lim_reg <= last_next;
        if (out_load)
        begin
            out_mag_reg     <= mag_next;
            out_pin_reg     <= pin_next;
            out_applied_reg <= applied_next;
        end
    end

endmodule
